// File: src/annas_pkg.sv
package annas_pkg;

   localparam int DataWidth    = 32;
   localparam int AxisWidth    = 35;
   localparam int SpacingWidth = 34;
   localparam int TickWidth    = 7;
   localparam int DecDigitsDefault = 3;
   localparam logic [TickWidth-1:0] TickCountReset = 7'd10;

   localparam int SpanWidth  = 34;
   localparam int ExpWidth   = 4;
   localparam int DecadeLast = 10;

   // nice mantissa code: 1, 2, 5 or 10 times a power of ten
   typedef enum logic [1:0] {
      MANT_ONE  = 2'd0,
      MANT_TWO  = 2'd1,
      MANT_FIVE = 2'd2,
      MANT_TEN  = 2'd3
   } mant_type;

   typedef logic [SpanWidth-1:0] span_type;

   // 10^e for e in 0..10
   function automatic span_type pow10(input logic [ExpWidth-1:0] e);
      span_type p;
      p = span_type'(1);
      for (int i = 0; i < DecadeLast; i++) begin
         if (i < int'(e)) p = span_type'(p * 10);
      end
      return p;
   endfunction

   function automatic span_type mant_scale(input mant_type m, input span_type p);
      span_type r;
      case (m)
         MANT_ONE:  r = p;
         MANT_TWO:  r = span_type'({p, 1'b0});
         MANT_FIVE: r = span_type'({p, 2'b00} + p);
         default:   r = span_type'({p, 3'b000} + {p, 1'b0});
      endcase
      return r;
   endfunction

endpackage

// File: src/annas_if.sv
interface annas_req_if;
   import annas_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [DataWidth-1:0] data_low;
   logic signed [DataWidth-1:0] data_high;
   modport source (output valid, output data_low, output data_high, input ready);
   modport sink   (input valid, input data_low, input data_high, output ready);
endinterface

interface annas_rsp_if;
   import annas_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [AxisWidth-1:0] axis_low;
   logic signed [AxisWidth-1:0] axis_high;
   logic [SpacingWidth-1:0]     tick_spacing;
   logic                        status;
   modport source (output valid, output axis_low, output axis_high,
                   output tick_spacing, output status, input ready);
   modport sink   (input valid, input axis_low, input axis_high,
                   input tick_spacing, input status, output ready);
endinterface

// File: src/annas_div.sv
// Pipelined restoring divider, one quotient bit per stage; unsigned.
module annas_div #(
   parameter int NumWidth = 36,
   parameter int DenWidth = 34
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [NumWidth-1:0] num,
   input  logic [DenWidth-1:0] den,
   output logic [NumWidth-1:0] quot,
   output logic                rem_nz
);
   localparam int RemWidth = DenWidth + 1;

   logic [NumWidth-1:0] n_ff   [NumWidth+1];
   logic [RemWidth-1:0] r_ff   [NumWidth+1];
   logic [DenWidth-1:0] d_ff   [NumWidth+1];

   assign n_ff[0] = num;
   assign r_ff[0] = '0;
   assign d_ff[0] = den;

   for (genvar s = 0; s < NumWidth; s++) begin : g_stage
      logic [RemWidth:0] trial;
      logic [RemWidth-1:0] shifted;
      assign shifted = {r_ff[s][RemWidth-2:0], n_ff[s][NumWidth-1]};
      assign trial = {1'b0, shifted} - {2'b00, d_ff[s]};
      always_ff @(posedge clock) begin
         if (enable) begin
            d_ff[s+1] <= d_ff[s];
            if (!trial[RemWidth]) begin
               r_ff[s+1] <= trial[RemWidth-1:0];
               n_ff[s+1] <= {n_ff[s][NumWidth-2:0], 1'b1};
            end else begin
               r_ff[s+1] <= shifted;
               n_ff[s+1] <= {n_ff[s][NumWidth-2:0], 1'b0};
            end
         end
      end
   end

   assign quot   = n_ff[NumWidth];
   assign rem_nz = |r_ff[NumWidth];
endmodule

// File: src/axis_nice_number_autoscale_unit.sv
// Channel | Dir | Handshake    | Payload
// req     | in  | valid/ready  | data_low, data_high (s32)
// rsp     | out | valid/ready  | axis_low, axis_high (s35), tick_spacing (u34), status
// csr     | in  | csr_wr_en    | tick_count (u7)
//
// One request per cycle is accepted while ready is high; each request passes through
// span, nice span, decade search, spacing, the 36-stage floor/ceil quotient pipeline,
// sign fix, split multiply and output registers in turn.
// The pipeline advances as one shift line; it holds entirely while the
// output register is full and not taken, so ready = !rsp_valid || rsp_ready.
// Reset (synchronous, active high) clears every valid bit and sets tick_count to 10.
module axis_nice_number_autoscale_unit #(
   parameter int DEC_DIGITS = annas_pkg::DecDigitsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   annas_req_if.sink                      req,
   annas_rsp_if.source                    rsp,
   input  logic                           csr_wr_en,
   input  logic [annas_pkg::TickWidth-1:0] csr_wr_data
);
   import annas_pkg::*;

   localparam int QW = 36;
   localparam int DivStages = QW;
   localparam span_type Unit = pow10(ExpWidth'(DEC_DIGITS));

   logic [TickWidth-1:0] tick_ff;
   logic advance;
   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) tick_ff <= TickCountReset;
      else if (csr_wr_en) tick_ff <= csr_wr_data;
   end

   // ---- stage 1: adjust max, span, error, tick count
   logic s1_v_ff, s1_err_ff;
   logic signed [AxisWidth-1:0] s1_lo_ff, s1_hi_ff;
   span_type s1_span_ff;
   logic [TickWidth-1:0] s1_n_ff;
   logic signed [AxisWidth-1:0] lo_x, hi_x, span_x;
   always_comb begin
      lo_x = AxisWidth'(req.data_low);
      hi_x = AxisWidth'(req.data_high);
      if (req.data_low == req.data_high) hi_x = hi_x + AxisWidth'(Unit);
      span_x = hi_x - lo_x;
   end
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (advance) s1_v_ff <= req.valid;
      if (advance) begin
         s1_lo_ff   <= lo_x;
         s1_hi_ff   <= hi_x;
         s1_err_ff  <= span_x < 0;
         s1_span_ff <= span_type'(span_x);
         s1_n_ff    <= (tick_ff == '0) ? TickWidth'(1) : tick_ff;
      end
   end

   // ---- stage 2: nice ceiling of span
   logic s2_v_ff, s2_err_ff;
   logic signed [AxisWidth-1:0] s2_lo_ff, s2_hi_ff;
   span_type s2_span_ff;
   logic [TickWidth-1:0] s2_n_ff;
   span_type p_c, nice_c;
   always_comb begin
      p_c = span_type'(1);
      for (int e = 1; e <= DecadeLast; e++) begin
         if (pow10(ExpWidth'(e)) <= s1_span_ff) p_c = pow10(ExpWidth'(e));
      end
      if (s1_span_ff <= p_c) nice_c = p_c;
      else if (s1_span_ff <= mant_scale(MANT_TWO, p_c)) nice_c = mant_scale(MANT_TWO, p_c);
      else if (s1_span_ff <= mant_scale(MANT_FIVE, p_c)) nice_c = mant_scale(MANT_FIVE, p_c);
      else nice_c = mant_scale(MANT_TEN, p_c);
   end
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (advance) s2_v_ff <= s1_v_ff;
      if (advance) begin
         s2_lo_ff <= s1_lo_ff; s2_hi_ff <= s1_hi_ff; s2_err_ff <= s1_err_ff;
         s2_span_ff <= nice_c; s2_n_ff <= s1_n_ff;
      end
   end

   // ---- stage 3: decade search of span / n
   localparam int ProdWidth = SpanWidth + TickWidth + 4;
   logic s3_v_ff, s3_err_ff, s3_small_ff;
   logic signed [AxisWidth-1:0] s3_lo_ff, s3_hi_ff;
   span_type s3_span_ff, s3_p_ff;
   logic [ProdWidth-1:0] s3_dp_ff;
   span_type p3;
   logic [ProdWidth-1:0] dp3;
   always_comb begin
      p3  = span_type'(1);
      dp3 = ProdWidth'(s2_n_ff);
      for (int e = 1; e <= DecadeLast; e++) begin
         if (ProdWidth'(s2_n_ff) * ProdWidth'(pow10(ExpWidth'(e))) <= ProdWidth'(s2_span_ff)) begin
            p3  = pow10(ExpWidth'(e));
            dp3 = ProdWidth'(s2_n_ff) * ProdWidth'(pow10(ExpWidth'(e)));
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (advance) s3_v_ff <= s2_v_ff;
      if (advance) begin
         s3_lo_ff <= s2_lo_ff; s3_hi_ff <= s2_hi_ff; s3_err_ff <= s2_err_ff;
         s3_span_ff <= s2_span_ff; s3_p_ff <= p3; s3_dp_ff <= dp3;
         s3_small_ff <= s2_span_ff < span_type'(s2_n_ff);
      end
   end

   // ---- stage 4: round mantissa with thresholds 1.5, 3, 7; prep operands
   logic s4_v_ff, s4_err_ff, s4_lo_neg_ff;
   logic signed [AxisWidth-1:0] s4_lo_ff, s4_hi_ff;
   span_type s4_d_ff;
   logic [ProdWidth+1:0] num2, dp15, dp3x, dp7;
   span_type d4;
   always_comb begin
      num2 = (ProdWidth+2)'({s3_span_ff, 1'b0});
      dp15 = {2'b00, s3_dp_ff} + {1'b0, s3_dp_ff, 1'b0};
      dp3x = dp15;
      dp7  = (ProdWidth+2)'({s3_dp_ff, 3'b000} - {3'b000, s3_dp_ff});
      if (s3_small_ff) d4 = span_type'(1);
      else if (num2 < dp15) d4 = s3_p_ff;
      else if ({2'b00, s3_span_ff} < dp3x) d4 = mant_scale(MANT_TWO, s3_p_ff);
      else if ({2'b00, s3_span_ff} < dp7) d4 = mant_scale(MANT_FIVE, s3_p_ff);
      else d4 = mant_scale(MANT_TEN, s3_p_ff);
   end
   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (advance) s4_v_ff <= s3_v_ff;
      if (advance) begin
         s4_lo_ff <= s3_lo_ff; s4_hi_ff <= s3_hi_ff; s4_err_ff <= s3_err_ff;
         s4_d_ff <= d4;
      end
   end

   // ---- divider pipeline on magnitudes
   logic [QW-1:0] lo_mag, hi_mag, lo_q, hi_q;
   logic lo_rnz, hi_rnz;
   assign lo_mag = s4_lo_ff[AxisWidth-1] ? QW'(-s4_lo_ff) : QW'(s4_lo_ff);
   assign hi_mag = s4_hi_ff[AxisWidth-1] ? QW'(-s4_hi_ff) : QW'(s4_hi_ff);
   assign s4_lo_neg_ff = s4_lo_ff[AxisWidth-1];

   annas_div #(.NumWidth(QW), .DenWidth(SpanWidth)) u_div_lo (
      .clock(clock), .enable(advance), .num(lo_mag), .den(s4_d_ff),
      .quot(lo_q), .rem_nz(lo_rnz));
   annas_div #(.NumWidth(QW), .DenWidth(SpanWidth)) u_div_hi (
      .clock(clock), .enable(advance), .num(hi_mag), .den(s4_d_ff),
      .quot(hi_q), .rem_nz(hi_rnz));

   // side pipeline for control alongside divider
   logic dl_v_ff [DivStages+1];
   logic dl_err_ff [DivStages+1];
   logic dl_ln_ff [DivStages+1];
   logic dl_hn_ff [DivStages+1];
   span_type dl_d_ff [DivStages+1];
   assign dl_v_ff[0] = s4_v_ff;
   assign dl_err_ff[0] = s4_err_ff;
   assign dl_ln_ff[0] = s4_lo_neg_ff;
   assign dl_hn_ff[0] = s4_hi_ff[AxisWidth-1];
   assign dl_d_ff[0] = s4_d_ff;
   for (genvar s = 0; s < DivStages; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) dl_v_ff[s+1] <= 1'b0;
         else if (advance) dl_v_ff[s+1] <= dl_v_ff[s];
         if (advance) begin
            dl_err_ff[s+1] <= dl_err_ff[s];
            dl_ln_ff[s+1]  <= dl_ln_ff[s];
            dl_hn_ff[s+1]  <= dl_hn_ff[s];
            dl_d_ff[s+1]   <= dl_d_ff[s];
         end
      end
   end

   // ---- stage M: signed quotients with floor/ceil correction
   logic m_v_ff, m_err_ff;
   logic signed [QW:0] m_ql_ff, m_qh_ff;
   span_type m_d_ff;
   logic signed [QW:0] ql, qh;
   always_comb begin
      // floor: negative with remainder -> -(q+1); ceil: positive with remainder -> q+1
      ql = dl_ln_ff[DivStages] ? -$signed({1'b0, lo_q}) - (QW+1)'(lo_rnz)
                               :  $signed({1'b0, lo_q});
      qh = dl_hn_ff[DivStages] ? -$signed({1'b0, hi_q})
                               :  $signed({1'b0, hi_q}) + (QW+1)'(hi_rnz);
   end
   always_ff @(posedge clock) begin
      if (reset) m_v_ff <= 1'b0;
      else if (advance) m_v_ff <= dl_v_ff[DivStages];
      if (advance) begin
         m_err_ff <= dl_err_ff[DivStages];
         m_ql_ff <= ql; m_qh_ff <= qh; m_d_ff <= dl_d_ff[DivStages];
      end
   end

   // ---- stage X: partial products with the spacing split in two halves,
   // keep only the bits that reach the 35-bit axis fields
   localparam int HalfWidth = SpanWidth / 2;
   localparam int HighBits  = AxisWidth - HalfWidth;
   logic x_v_ff, x_err_ff;
   logic [AxisWidth-1:0] x_ll_ff, x_hl_ff;
   logic [HighBits-1:0]  x_lh_ff, x_hh_ff;
   span_type x_d_ff;
   logic [AxisWidth-1:0] ql_lo, qh_lo, d_lo;
   logic [HighBits-1:0]  d_hi;
   assign ql_lo = m_ql_ff[AxisWidth-1:0];
   assign qh_lo = m_qh_ff[AxisWidth-1:0];
   assign d_lo  = AxisWidth'(m_d_ff[HalfWidth-1:0]);
   assign d_hi  = HighBits'(m_d_ff[SpanWidth-1:HalfWidth]);
   always_ff @(posedge clock) begin
      if (reset) x_v_ff <= 1'b0;
      else if (advance) x_v_ff <= m_v_ff;
      if (advance) begin
         x_err_ff <= m_err_ff;
         x_d_ff   <= m_d_ff;
         x_ll_ff  <= ql_lo * d_lo;
         x_lh_ff  <= ql_lo[HighBits-1:0] * d_hi;
         x_hl_ff  <= qh_lo * d_lo;
         x_hh_ff  <= qh_lo[HighBits-1:0] * d_hi;
      end
   end

   // ---- output register: sum partial products
   logic rv_ff, rs_ff;
   logic signed [AxisWidth-1:0] rl_ff, rh_ff;
   span_type rd_ff;
   logic [AxisWidth-1:0] pl, ph;
   assign pl = x_ll_ff + {x_lh_ff, {HalfWidth{1'b0}}};
   assign ph = x_hl_ff + {x_hh_ff, {HalfWidth{1'b0}}};
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (advance) rv_ff <= x_v_ff;
      if (advance) begin
         rs_ff <= x_err_ff;
         rl_ff <= x_err_ff ? '0 : pl;
         rh_ff <= x_err_ff ? '0 : ph;
         rd_ff <= x_err_ff ? '0 : x_d_ff;
      end
   end

   assign rsp.valid        = rv_ff;
   assign rsp.status       = rs_ff;
   assign rsp.axis_low     = rl_ff;
   assign rsp.axis_high    = rh_ff;
   assign rsp.tick_spacing = rd_ff;

   // spacing is never zero on a good result
   a_spacing_nz: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.status |-> rsp.tick_spacing != '0) else $error("zero spacing");
   // error results carry zero axis fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status |-> rsp.axis_low == '0 && rsp.axis_high == '0)
      else $error("error result not zero");
   // axis range ordered on good results
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.status |-> rsp.axis_low <= rsp.axis_high) else $error("range order");
   // stalled output holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.axis_low)) else $error("lost result");
endmodule
